// ----- hdl/prim_minimum_spanning_tree_assert.svh -----
// assertion macros for the spanning tree block, sampled on clk, off during reset
`ifndef PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH
`define PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH

// consequent must hold in the same cycle
`define MST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prim_mst: same-cycle check failed");

// consequent must hold in the next cycle
`define MST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prim_mst: next-cycle check failed");

`endif

// ----- hdl/prim_mst_pkg.sv -----
`default_nettype none

package prim_mst_pkg;

    localparam int NODE_W    = 6;
    localparam int FUNC_W    = 2;
    localparam int EDGE_W    = 16;
    localparam int KEY_OUT_W = 17;
    localparam int CFG_W     = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE2,
        ST_INIT,
        ST_PASS,
        ST_NEXT,
        ST_ERD,
        ST_ELOAD
    } state_t;

    typedef struct packed {
        logic              load;
        logic [NODE_W-1:0] node;
        logic              last;
    } emit_t;

endpackage

`default_nettype wire

// ----- hdl/prim_mst_relax.sv -----
`default_nettype none

module prim_mst_relax #(
    parameter int WEIGHT_BITS = 16,
    localparam int KW = WEIGHT_BITS + 1
) (
    input  wire logic [WEIGHT_BITS-1:0] w,
    input  wire logic [KW-1:0]          key,
    input  wire logic                   in_tree,
    input  wire logic                   is_u,
    input  wire logic                   min_found,
    input  wire logic [KW-1:0]          min_key,
    output logic                        upd,
    output logic [KW-1:0]               key_new,
    output logic                        take
);

    logic          active;
    logic [KW-1:0] w_ext;

    always_comb
    begin
        w_ext   = {1'b0, w};
        // the node that just joined counts as already in the tree
        active  = !in_tree && !is_u;
        upd     = active && (w != '0) && (w_ext < key);
        key_new = upd ? w_ext : key;
        // strict compare on an ascending scan keeps the lowest index on ties
        take    = active && (!min_found || (key_new < min_key));
    end

endmodule

`default_nettype wire

// ----- hdl/prim_mst_ram.sv -----
`default_nettype none

module prim_mst_ram #(
    parameter int AW = 12,
    parameter int DW = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic [DW-1:0]      rdata
);

    logic [DW-1:0] mem [0:(1 << AW)-1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/prim_mst_ctrl.sv -----
`default_nettype none

module prim_mst_ctrl import prim_mst_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int WEIGHT_BITS = 16,
    localparam int NB = $clog2(MAX_NODES),
    localparam int CW = $clog2(MAX_NODES + 1),
    localparam int AW = 2 * NB,
    localparam int KW = WEIGHT_BITS + 1,
    localparam int NW = KW + NB + 2
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [CW-1:0]          n_use,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [FUNC_W-1:0]      func,
    input  wire logic [NODE_W-1:0]      node_a,
    input  wire logic [NODE_W-1:0]      node_b,
    input  wire logic [EDGE_W-1:0]      edge_weight,
    input  wire logic                   out_free,
    output emit_t                       emit,
    output logic                        wm_we,
    output logic [AW-1:0]               wm_waddr,
    output logic [WEIGHT_BITS-1:0]      wm_wdata,
    output logic                        wm_re,
    output logic [AW-1:0]               wm_raddr,
    input  wire logic [WEIGHT_BITS-1:0] wm_rdata,
    output logic                        nm_we,
    output logic [NB-1:0]               nm_waddr,
    output logic [NW-1:0]               nm_wdata,
    output logic                        nm_re,
    output logic [NB-1:0]               nm_raddr,
    input  wire logic [NW-1:0]          nm_rdata
);

    localparam logic [KW-1:0]     KEY_NONE = {1'b1, {WEIGHT_BITS{1'b0}}};
    localparam logic [NODE_W:0]   MAXN_L   = (NODE_W + 1)'(MAX_NODES);

    state_t                  state_reg, state_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic [NB-1:0]           ea_reg, ea_next;
    logic [NB-1:0]           eb_reg, eb_next;
    logic [WEIGHT_BITS-1:0]  ew_reg, ew_next;
    logic [NB-1:0]           u_reg, u_next;
    logic [CW-1:0]           v_reg, v_next;
    logic                    rd_on_reg, rd_on_next;
    logic                    p_valid_reg, p_valid_next;
    logic [NB-1:0]           p_v_reg, p_v_next;
    logic                    p_last_reg, p_last_next;
    logic [CW-1:0]           step_reg, step_next;
    logic                    min_found_reg, min_found_next;
    logic [KW-1:0]           min_key_reg, min_key_next;
    logic [NB-1:0]           min_idx_reg, min_idx_next;
    logic [CW-1:0]           i_reg, i_next;

    logic [CW-1:0]           n_last;
    logic                    ends_ok;
    logic [WEIGHT_BITS-1:0]  w_in;
    logic [KW-1:0]           cur_key;
    logic [NB-1:0]           cur_par;
    logic                    cur_has;
    logic                    cur_in;
    logic                    is_u;
    logic                    upd;
    logic [KW-1:0]           key_new;
    logic                    take;
    logic [NW-1:0]           init_entry;
    logic [NW-1:0]           stage_entry;

    assign n_last  = n_use - CW'(1);
    assign ends_ok = ({1'b0, node_a} < MAXN_L) && ({1'b0, node_b} < MAXN_L);
    assign w_in    = WEIGHT_BITS'(edge_weight);

    assign cur_key = nm_rdata[KW-1:0];
    assign cur_par = nm_rdata[KW+NB-1:KW];
    assign cur_has = nm_rdata[KW+NB];
    assign cur_in  = nm_rdata[KW+NB+1];
    assign is_u    = (p_v_reg == u_reg);

    prim_mst_relax #(
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_relax (
        .w        (wm_rdata),
        .key      (cur_key),
        .in_tree  (cur_in),
        .is_u     (is_u),
        .min_found(min_found_reg),
        .min_key  (min_key_reg),
        .upd      (upd),
        .key_new  (key_new),
        .take     (take)
    );

    assign init_entry  = {1'b0, 1'b0, {NB{1'b0}},
                          (v_reg == '0) ? {KW{1'b0}} : KEY_NONE};
    assign stage_entry = {cur_in | is_u, cur_has | upd, upd ? u_reg : cur_par, key_new};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func)
                        FUNC_EDGE:  state_next = ends_ok ? ST_EDGE2 : ST_IDLE;
                        FUNC_RUN:   state_next = ST_INIT;
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EDGE2:
            begin
                state_next = ST_IDLE;
            end
            ST_INIT:
            begin
                if (v_reg == n_last)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (p_valid_reg && p_last_reg)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (step_reg == n_last)
                begin
                    state_next = (n_use == CW'(1)) ? ST_IDLE : ST_ERD;
                end
                else
                begin
                    state_next = ST_PASS;
                end
            end
            ST_ERD:
            begin
                state_next = ST_ELOAD;
            end
            ST_ELOAD:
            begin
                if (out_free)
                begin
                    state_next = (i_reg == n_last) ? ST_IDLE : ST_ERD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        emit      = '0;
        wm_we     = 1'b0;
        wm_waddr  = clr_reg;
        wm_wdata  = '0;
        wm_re     = 1'b0;
        wm_raddr  = {u_reg, v_reg[NB-1:0]};
        nm_we     = 1'b0;
        nm_waddr  = p_v_reg;
        nm_wdata  = stage_entry;
        nm_re     = 1'b0;
        nm_raddr  = v_reg[NB-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                wm_we = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                wm_we    = in_valid && (func == FUNC_EDGE) && ends_ok;
                wm_waddr = {node_a[NB-1:0], node_b[NB-1:0]};
                wm_wdata = w_in;
            end
            ST_EDGE2:
            begin
                wm_we    = 1'b1;
                wm_waddr = {eb_reg, ea_reg};
                wm_wdata = ew_reg;
            end
            ST_INIT:
            begin
                nm_we    = 1'b1;
                nm_waddr = v_reg[NB-1:0];
                nm_wdata = init_entry;
            end
            ST_PASS:
            begin
                wm_re = rd_on_reg;
                nm_re = rd_on_reg;
                nm_we = p_valid_reg;
            end
            ST_NEXT:
            begin
                nm_re = 1'b0;
            end
            ST_ERD:
            begin
                nm_re    = 1'b1;
                nm_raddr = i_reg[NB-1:0];
            end
            ST_ELOAD:
            begin
                emit.load = out_free;
                emit.node = NODE_W'(i_reg);
                emit.last = (i_reg == n_last);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        clr_next       = clr_reg;
        ea_next        = ea_reg;
        eb_next        = eb_reg;
        ew_next        = ew_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        rd_on_next     = rd_on_reg;
        p_valid_next   = 1'b0;
        p_v_next       = p_v_reg;
        p_last_next    = p_last_reg;
        step_next      = step_reg;
        min_found_next = min_found_reg;
        min_key_next   = min_key_reg;
        min_idx_next   = min_idx_reg;
        i_next         = i_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                ea_next  = node_a[NB-1:0];
                eb_next  = node_b[NB-1:0];
                ew_next  = w_in;
                clr_next = '0;
                v_next   = '0;
            end
            ST_INIT:
            begin
                v_next = v_reg + CW'(1);
                if (v_reg == n_last)
                begin
                    v_next         = '0;
                    rd_on_next     = 1'b1;
                    u_next         = '0;
                    step_next      = '0;
                    min_found_next = 1'b0;
                end
            end
            ST_PASS:
            begin
                if (rd_on_reg)
                begin
                    p_valid_next = 1'b1;
                    p_v_next     = v_reg[NB-1:0];
                    p_last_next  = (v_reg == n_last);
                    v_next       = v_reg + CW'(1);
                    rd_on_next   = (v_reg != n_last);
                end
                if (p_valid_reg && take)
                begin
                    min_found_next = 1'b1;
                    min_key_next   = key_new;
                    min_idx_next   = p_v_reg;
                end
            end
            ST_NEXT:
            begin
                step_next      = step_reg + CW'(1);
                u_next         = min_idx_reg;
                v_next         = '0;
                rd_on_next     = 1'b1;
                min_found_next = 1'b0;
                i_next         = CW'(1);
            end
            ST_ELOAD:
            begin
                if (out_free)
                begin
                    i_next = i_reg + CW'(1);
                end
            end
            default:
            begin
                i_next = i_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rd_on_reg     <= 1'b0;
            p_valid_reg   <= 1'b0;
            min_found_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rd_on_reg     <= rd_on_next;
            p_valid_reg   <= p_valid_next;
            min_found_reg <= min_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ea_reg      <= ea_next;
        eb_reg      <= eb_next;
        ew_reg      <= ew_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        p_v_reg     <= p_v_next;
        p_last_reg  <= p_last_next;
        step_reg    <= step_next;
        min_key_reg <= min_key_next;
        min_idx_reg <= min_idx_next;
        i_reg       <= i_next;
    end

endmodule

`default_nettype wire

// ----- hdl/prim_minimum_spanning_tree.sv -----
`default_nettype none

// Prim spanning tree over a stored weight matrix (weight 0 = no edge). After reset the
// matrix is swept to zero, one entry a cycle over 2^(2*clog2(MAX_NODES)) entries
// (4096 at the defaults), with in_ready low meanwhile; a clear request takes the same
// sweep. An add-edge request makes one write per direction through the single write
// port of the matrix RAM. A run over n nodes first initializes the node table, then
// makes n passes, every pass streaming one matrix row and the node table through the
// shared relax/compare unit, then reads each result out of the node table, waiting
// while the result side stalls. Requests are taken one at a time; a finished result
// waits in the output register while the next request is taken.
module prim_minimum_spanning_tree import prim_mst_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [FUNC_W-1:0]    func,
    input  wire logic [NODE_W-1:0]    node_a,
    input  wire logic [NODE_W-1:0]    node_b,
    input  wire logic [EDGE_W-1:0]    edge_weight,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [NODE_W-1:0]         node,
    output logic [NODE_W-1:0]         parent,
    output logic                      has_parent,
    output logic [KEY_OUT_W-1:0]      key_weight,
    output logic                      last
);

    localparam int NB = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int AW = 2 * NB;
    localparam int KW = WEIGHT_BITS + 1;
    localparam int NW = KW + NB + 2;
    localparam logic [CFG_W-1:0]     MAXN_C       = CFG_W'(MAX_NODES);
    localparam logic [KEY_OUT_W-1:0] KEY_OUT_NONE = KEY_OUT_W'({1'b1, {WEIGHT_BITS{1'b0}}});

    logic [CFG_W-1:0]       count_reg, count_next;
    logic [CW-1:0]          n_use;

    logic                   out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]      node_reg;
    logic [NODE_W-1:0]      parent_reg;
    logic                   has_reg;
    logic [KEY_OUT_W-1:0]   key_reg;
    logic                   last_reg;

    emit_t                  emit;
    logic                   out_free;

    logic                   wm_we;
    logic [AW-1:0]          wm_waddr;
    logic [WEIGHT_BITS-1:0] wm_wdata;
    logic                   wm_re;
    logic [AW-1:0]          wm_raddr;
    logic [WEIGHT_BITS-1:0] wm_rdata;
    logic                   nm_we;
    logic [NB-1:0]          nm_waddr;
    logic [NW-1:0]          nm_wdata;
    logic                   nm_re;
    logic [NB-1:0]          nm_raddr;
    logic [NW-1:0]          nm_rdata;

    // count of 0 runs as 1, above the matrix size runs as the matrix size
    always_comb
    begin
        count_next = cfg_we ? cfg_wdata : count_reg;
        if (count_reg == '0)
        begin
            n_use = CW'(1);
        end
        else if (count_reg > MAXN_C)
        begin
            n_use = CW'(MAX_NODES);
        end
        else
        begin
            n_use = CW'(count_reg);
        end
    end

    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid_next = emit.load || (out_valid_reg && !out_ready);

    prim_mst_ctrl #(
        .MAX_NODES  (MAX_NODES),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .n_use      (n_use),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .node_a     (node_a),
        .node_b     (node_b),
        .edge_weight(edge_weight),
        .out_free   (out_free),
        .emit       (emit),
        .wm_we      (wm_we),
        .wm_waddr   (wm_waddr),
        .wm_wdata   (wm_wdata),
        .wm_re      (wm_re),
        .wm_raddr   (wm_raddr),
        .wm_rdata   (wm_rdata),
        .nm_we      (nm_we),
        .nm_waddr   (nm_waddr),
        .nm_wdata   (nm_wdata),
        .nm_re      (nm_re),
        .nm_raddr   (nm_raddr),
        .nm_rdata   (nm_rdata)
    );

    prim_mst_ram #(
        .AW(AW),
        .DW(WEIGHT_BITS)
    ) u_wmat (
        .clk  (clk),
        .we   (wm_we),
        .waddr(wm_waddr),
        .wdata(wm_wdata),
        .re   (wm_re),
        .raddr(wm_raddr),
        .rdata(wm_rdata)
    );

    // per-node entry: {in_tree, has_parent, parent, key}
    prim_mst_ram #(
        .AW(NB),
        .DW(NW)
    ) u_nodes (
        .clk  (clk),
        .we   (nm_we),
        .waddr(nm_waddr),
        .wdata(nm_wdata),
        .re   (nm_re),
        .raddr(nm_raddr),
        .rdata(nm_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            node_reg   <= emit.node;
            parent_reg <= NODE_W'(nm_rdata[KW+NB-1:KW]);
            has_reg    <= nm_rdata[KW+NB];
            key_reg    <= KEY_OUT_W'(nm_rdata[KW-1:0]);
            last_reg   <= emit.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign node       = node_reg;
    assign parent     = parent_reg;
    assign has_parent = has_reg;
    assign key_weight = key_reg;
    assign last       = last_reg;

`include "prim_minimum_spanning_tree_assert.svh"

    `MST_ASSERT_NEXT(a_run_busy, in_valid && in_ready && func == FUNC_RUN, !in_ready)
    `MST_ASSERT_SAME(a_last_node, out_valid_reg && last_reg, node_reg == NODE_W'(n_use - CW'(1)))
    `MST_ASSERT_SAME(a_unreached, out_valid_reg && !has_reg, key_reg == KEY_OUT_NONE && parent_reg == '0)
    `MST_ASSERT_SAME(a_no_overrun, emit.load, !out_valid_reg || out_ready)

endmodule

`default_nettype wire
